// ===== rtl/u8dec_pkg.sv =====
// shared constants, status codes and helpers for the utf-8 to utf-32 decoder
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

  localparam int CNT_W = 16;   // width of the position and character counters
  localparam int CP_W  = 31;   // decoded code point width
  localparam int REM_W = 3;    // continuation bytes still expected
  localparam int ST_W  = 2;
  localparam int RPT_W = 16;   // width of the reported count fields

  localparam logic [ST_W-1:0] ST_CHAR     = 2'd0;
  localparam logic [ST_W-1:0] ST_ERROR    = 2'd1;
  localparam logic [ST_W-1:0] ST_END_OK   = 2'd2;
  localparam logic [ST_W-1:0] ST_END_FAIL = 2'd3;

  typedef logic [CNT_W-1:0] cnt_t;

  // saturating increment at the top of the counter range
  function automatic cnt_t inc_sat(input cnt_t v);
    cnt_t r;
    r = (v == {CNT_W{1'b1}}) ? v : v + cnt_t'(1);
    return r;
  endfunction

  // clamp a counter value into the reported field
  function automatic logic [RPT_W-1:0] sat_rpt(input cnt_t v);
    logic [CNT_W+RPT_W-1:0] wide;
    logic [RPT_W-1:0]       r;
    wide = {{RPT_W{1'b0}}, v};
    r = (wide > (CNT_W+RPT_W)'({RPT_W{1'b1}})) ? {RPT_W{1'b1}} : wide[RPT_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8_to_utf32_decoder.sv =====
// utf-8 to utf-32 stream decoder: one string byte per transaction
//
// in_byte carries one byte of a zero-terminated utf-8 string per transaction
// (in_valid / in_ready). each byte gives zero or one result on the out_
// channel: a decoded character (status 0), an error with the offending byte
// index (status 1), or an end marker with the character count (status 2 clean,
// status 3 after an error). lead forms of one to six bytes are accepted, with
// no overlong or surrogate checks. after an error all bytes are dropped up to
// the zero terminator; a terminator inside a sequence gives only the error.
// a result appears on the out_ ports in the cycle after its byte is
// accepted. throughput: one byte per cycle while no result is held; the decode step
// is a single pass of shift-and-or logic into the result register.
// when the receiver stalls, the result register holds its transaction and
// in_ready drops, so no byte is taken until the result is drained (in_ready
// follows out_ready in the same cycle so back-to-back flow is kept).
// synchronous active-low reset clears the decoder state and out_valid (the result
// payload has no reset); the next byte starts a new string at position zero.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf32_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [u8dec_pkg::CP_W-1:0]       out_code_point,
  output logic [u8dec_pkg::ST_W-1:0]       out_status,
  output logic [u8dec_pkg::RPT_W-1:0]      out_byte_position,
  output logic [u8dec_pkg::RPT_W-1:0]      out_char_count
);
  import u8dec_pkg::*;

  logic [CP_W-1:0]  pv_r, pv_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  cnt_t             pos_r, pos_nxt;
  cnt_t             chr_r, chr_nxt;
  logic             disc_r, disc_nxt;

  logic             ov_r;
  logic [CP_W-1:0]  ocp_r, ocp_nxt;
  logic [ST_W-1:0]  ost_r, ost_nxt;
  logic [RPT_W-1:0] opos_r, opos_nxt;
  logic [RPT_W-1:0] ocnt_r, ocnt_nxt;
  logic             emit;
  logic             in_fire;
  logic             is_cont;

  assign in_ready = !ov_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_cont  = (in_byte[7:6] == 2'b10);

  always_comb begin
    pv_nxt   = pv_r;
    rem_nxt  = rem_r;
    pos_nxt  = pos_r;
    chr_nxt  = chr_r;
    disc_nxt = disc_r;
    emit     = 1'b0;
    ocp_nxt  = '0;
    ost_nxt  = ST_CHAR;
    opos_nxt = '0;
    ocnt_nxt = sat_rpt(chr_r);
    if (disc_r) begin
      if (in_byte == 8'h00) begin
        emit     = 1'b1;
        ost_nxt  = ST_END_FAIL;
        pv_nxt   = '0;
        rem_nxt  = '0;
        pos_nxt  = '0;
        chr_nxt  = '0;
        disc_nxt = 1'b0;
      end else begin
        pos_nxt = inc_sat(pos_r);
      end
    end else if (rem_r != '0) begin
      if (is_cont) begin
        pv_nxt  = {pv_r[CP_W-7:0], in_byte[5:0]};
        rem_nxt = rem_r - REM_W'(1);
        pos_nxt = inc_sat(pos_r);
        if (rem_r == REM_W'(1)) begin
          chr_nxt  = inc_sat(chr_r);
          emit     = 1'b1;
          ocp_nxt  = {pv_r[CP_W-7:0], in_byte[5:0]};
          ocnt_nxt = sat_rpt(inc_sat(chr_r));
        end
      end else begin
        emit     = 1'b1;
        ost_nxt  = ST_ERROR;
        opos_nxt = sat_rpt(pos_r);
        pv_nxt   = '0;
        rem_nxt  = '0;
        if (in_byte == 8'h00) begin
          pos_nxt = '0;
          chr_nxt = '0;
        end else begin
          disc_nxt = 1'b1;
          pos_nxt  = inc_sat(pos_r);
        end
      end
    end else if (in_byte == 8'h00) begin
      emit    = 1'b1;
      ost_nxt = ST_END_OK;
      pv_nxt  = '0;
      pos_nxt = '0;
      chr_nxt = '0;
    end else begin
      pos_nxt = inc_sat(pos_r);
      priority if (!in_byte[7]) begin
        chr_nxt  = inc_sat(chr_r);
        emit     = 1'b1;
        ocp_nxt  = CP_W'(in_byte);
        ocnt_nxt = sat_rpt(inc_sat(chr_r));
      end else if (is_cont || in_byte[7:1] == 7'b1111111) begin
        // stray continuation or 0xfe / 0xff lead
        disc_nxt = 1'b1;
        emit     = 1'b1;
        ost_nxt  = ST_ERROR;
        opos_nxt = sat_rpt(pos_r);
      end else if (!in_byte[5]) begin
        pv_nxt  = CP_W'(in_byte[4:0]);
        rem_nxt = REM_W'(1);
      end else if (!in_byte[4]) begin
        pv_nxt  = CP_W'(in_byte[3:0]);
        rem_nxt = REM_W'(2);
      end else if (!in_byte[3]) begin
        pv_nxt  = CP_W'(in_byte[2:0]);
        rem_nxt = REM_W'(3);
      end else if (!in_byte[2]) begin
        pv_nxt  = CP_W'(in_byte[1:0]);
        rem_nxt = REM_W'(4);
      end else begin
        pv_nxt  = CP_W'(in_byte[0]);
        rem_nxt = REM_W'(5);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      rem_r  <= '0;
      pos_r  <= '0;
      chr_r  <= '0;
      disc_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        pv_r   <= pv_nxt;
        rem_r  <= rem_nxt;
        pos_r  <= pos_nxt;
        chr_r  <= chr_nxt;
        disc_r <= disc_nxt;
      end
      if (in_fire) begin
        ov_r <= emit;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      ocp_r  <= ocp_nxt;
      ost_r  <= ost_nxt;
      opos_r <= opos_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_code_point    = ocp_r;
  assign out_status        = ost_r;
  assign out_byte_position = opos_r;
  assign out_char_count    = ocnt_r;

  a_disc_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (rem_r == '0))
    else $error("discard mode with an open sequence");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= REM_W'(5))
    else $error("continuation count out of range");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_byte == 8'h00) |=> (pos_r == '0 && chr_r == '0 && !disc_r && rem_r == '0))
    else $error("terminator did not return decoder to idle");

  a_char_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_ERROR) |-> (out_byte_position == '0))
    else $error("byte position set on a non-error result");

endmodule

`default_nettype wire

// ===== tb/sv/utf8_to_utf32_decoder_tb.sv =====
// testbench for the utf-8 to utf-32 stream decoder
`timescale 1ns / 1ps

module utf8_to_utf32_decoder_tb;
  import u8dec_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [ST_W-1:0]  st;
    logic [RPT_W-1:0] pos;
    logic [RPT_W-1:0] cnt;
  } dec_result_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte   = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CP_W-1:0]  out_code_point;
  logic [ST_W-1:0]  out_status;
  logic [RPT_W-1:0] out_byte_position;
  logic [RPT_W-1:0] out_char_count;

  // decoder state as predicted from the accepted bytes
  logic [CP_W-1:0]  dec_partial    = '0;
  logic [REM_W-1:0] dec_remaining  = '0;
  cnt_t             dec_position   = '0;
  cnt_t             dec_chars      = '0;
  logic             dec_discarding = 1'b0;

  dec_result_t decoded_q[$];
  int          bad_results    = 0;
  int          cycle_count    = 0;
  int          bytes_sent     = 0;
  bit          idle_en        = 1'b1;
  int          rx_hold_cycles = 0;

  utf8_to_utf32_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_point    (out_code_point),
    .out_status        (out_status),
    .out_byte_position (out_byte_position),
    .out_char_count    (out_char_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cnt_t count_up(input cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [RPT_W-1:0] report_field(input cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > ((64'd1 << RPT_W) - 64'd1)) ? '1 : w[RPT_W-1:0];
  endfunction

  function automatic void push_result(input logic [CP_W-1:0] cp, input logic [ST_W-1:0] st,
                                      input cnt_t pos);
    dec_result_t r;
    r.cp  = cp;
    r.st  = st;
    r.pos = report_field(pos);
    r.cnt = report_field(dec_chars);
    decoded_q.push_back(r);
  endfunction

  function automatic void clear_decoder();
    dec_partial    = '0;
    dec_remaining  = '0;
    dec_position   = '0;
    dec_chars      = '0;
    dec_discarding = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    cnt_t pos_now;
    pos_now = dec_position;
    if (dec_discarding) begin
      if (b == 8'h00) begin
        push_result('0, ST_END_FAIL, '0);
        clear_decoder();
      end else begin
        dec_position = count_up(dec_position);
      end
    end else if (dec_remaining != '0) begin
      if (b[7:6] == 2'b10) begin
        dec_partial   = {dec_partial[CP_W-7:0], b[5:0]};
        dec_remaining = dec_remaining - 1'b1;
        dec_position  = count_up(dec_position);
        if (dec_remaining == '0) begin
          dec_chars = count_up(dec_chars);
          push_result(dec_partial, ST_CHAR, '0);
        end
      end else begin
        push_result('0, ST_ERROR, pos_now);
        // a terminator inside a sequence closes the string with the error alone
        if (b == 8'h00) begin
          clear_decoder();
        end else begin
          dec_discarding = 1'b1;
          dec_remaining  = '0;
          dec_partial    = '0;
          dec_position   = count_up(dec_position);
        end
      end
    end else if (b == 8'h00) begin
      push_result('0, ST_END_OK, '0);
      clear_decoder();
    end else begin
      dec_position = count_up(dec_position);
      if (b < 8'h80) begin
        dec_chars = count_up(dec_chars);
        push_result(CP_W'(b), ST_CHAR, '0);
      end else if (b < 8'hC0 || b >= 8'hFE) begin
        dec_discarding = 1'b1;
        push_result('0, ST_ERROR, pos_now);
      end else if (b < 8'hE0) begin
        dec_partial   = CP_W'(b[4:0]);
        dec_remaining = REM_W'(1);
      end else if (b < 8'hF0) begin
        dec_partial   = CP_W'(b[3:0]);
        dec_remaining = REM_W'(2);
      end else if (b < 8'hF8) begin
        dec_partial   = CP_W'(b[2:0]);
        dec_remaining = REM_W'(3);
      end else if (b < 8'hFC) begin
        dec_partial   = CP_W'(b[1:0]);
        dec_remaining = REM_W'(4);
      end else begin
        dec_partial   = CP_W'(b[0]);
        dec_remaining = REM_W'(5);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!dec_discarding) bytes_sent++;
    decode_byte(b);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one character: well formed, or cut short and followed by a non-continuation byte
  task automatic send_random_char(input bit broken);
    int         r;
    int         len;
    int         n_cont;
    logic [7:0] lead;
    logic [7:0] bad;
    r    = $urandom_range(0, 99);
    len  = (r < 40) ? 1 : (r < 65) ? 2 : (r < 80) ? 3 : (r < 90) ? 4 : (r < 95) ? 5 : 6;
    if (broken && len == 1) len = 2;
    lead = 8'($urandom);
    case (len)
      1:       lead = {1'b0, lead[6:0]};
      2:       lead = {3'b110, lead[4:0]};
      3:       lead = {4'b1110, lead[3:0]};
      4:       lead = {5'b11110, lead[2:0]};
      5:       lead = {6'b111110, lead[1:0]};
      default: lead = {7'b1111110, lead[0]};
    endcase
    n_cont = broken ? $urandom_range(0, len - 2) : len - 1;
    bad    = 8'($urandom);
    if (bad[7:6] == 2'b10) bad[6] = 1'b1;
    if ($urandom_range(0, 3) == 0) bad = 8'h00;
    send_byte(lead);
    repeat (n_cont) send_byte({2'b10, 6'($urandom)});
    if (broken) send_byte(bad);
  endtask

  task automatic send_random_string();
    int n_chars;
    int pick;
    n_chars = $urandom_range(0, 24);
    repeat (n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) send_random_char(1'b0);
      else if (pick < 94) send_byte(8'($urandom_range(1, 255)));
      else send_random_char(1'b1);
    end
    send_byte(8'h00);
  endtask

  task automatic test_lead_forms();
    // empty string, then one, two, four, five and six byte forms up to the largest code point
    send_bytes('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00});
  endtask

  task automatic test_error_cases();
    // stray continuation, bad leads, broken sequence, terminator inside a sequence
    send_bytes('{8'h41, 8'hBF, 8'hC3, 8'h00, 8'hFE, 8'h00, 8'hFF, 8'h00,
                 8'hE2, 8'h82, 8'h41, 8'h00, 8'hC3, 8'h00});
  endtask

  task automatic test_backpressure();
    rx_hold_cycles = 300;
    repeat (30) send_byte(8'($urandom_range(1, 127)));
    send_bytes('{8'hE2, 8'h82, 8'hAC, 8'h00});
  endtask

  task automatic test_random(input int n_bytes);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) send_random_string();
  endtask

  task automatic test_long_string();
    // a long ascii run back to back, then an error late in the string
    repeat (150) send_byte(8'($urandom_range(1, 127)));
    send_bytes('{8'h80, 8'h41, 8'hC3, 8'h00});
  endtask

  task automatic test_drain_pause();
    send_random_string();
    wait_drain();
    send_random_string();
  endtask

  // receiver: random stall bursts plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    dec_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (decoded_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected transaction: cp %h st %0d pos %0d cnt %0d",
                   out_code_point, out_status, out_byte_position, out_char_count);
      end else begin
        want = decoded_q.pop_front();
        if (out_code_point !== want.cp || out_status !== want.st ||
            out_byte_position !== want.pos || out_char_count !== want.cnt) begin
          bad_results++;
          if (bad_results <= 10)
            $display({"mismatch: want cp %h st %0d pos %0d cnt %0d, ",
                      "got cp %h st %0d pos %0d cnt %0d"},
                     want.cp, want.st, want.pos, want.cnt,
                     out_code_point, out_status, out_byte_position, out_char_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lead_forms();
    test_error_cases();
    test_backpressure();
    test_random(350);
    test_drain_pause();
    test_random(350);
    idle_en = 1'b0;
    test_long_string();
    test_random(250);
    wait_drain();
    if (bad_results == 0 && decoded_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/u8dec_pkg.sv
rtl/utf8_to_utf32_decoder.sv
tb/sv/utf8_to_utf32_decoder_tb.sv
